[rtl/ssbh_pkg.sv]
// shared constants and types for the swept sphere against box hit test
// no dependencies; every other file imports it
package ssbh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int HALF_W    = 31;
  localparam int NUM_W     = 36;
  localparam int MAG_W     = 35;
  localparam int QUOT_W    = TIME_BITS + 2;
  localparam int REM_W     = MAG_W + TIME_BITS;
  localparam int TIME_W    = QUOT_W + 1;
  localparam int DIV_LAT   = QUOT_W + 3;
  localparam int ADDR_W    = 3;

  // below 1e-5 units of motion the axis counts as still
  localparam logic [CRD_W-1:0] STILL_LIM =
    CRD_W'(((64'd1 << FRAC_BITS) + 64'd99999) / 64'd100000);

  localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(64'd2 << TIME_BITS);
  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(64'd1 << TIME_BITS);

  localparam logic [HALF_W-1:0] RADIUS_RESET = HALF_W'(32768);
  localparam logic              REG_RADIUS   = 1'b0;

  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;
  localparam logic [1:0] NORM_ZERO = 2'b00;

  typedef logic signed [TIME_W-1:0] time_t;

  typedef struct packed {
    logic [2:0] still;
    logic [2:0] contained;
  } side_t;

  typedef struct packed {
    logic                 hit;
    logic [TIME_BITS:0]   hit_time;
    logic [1:0]           normal_x;
    logic [1:0]           normal_y;
    logic [1:0]           normal_z;
  } res_t;

endpackage

[rtl/ssbh_if.sv]
// query and result channels of the swept sphere box test
// depends on ssbh_pkg
interface ssbh_in_if;
  import ssbh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CRD_W-1:0]  center_x, center_y, center_z;
  logic signed [CRD_W-1:0]  move_x, move_y, move_z;
  logic signed [CRD_W-1:0]  box_x, box_y, box_z;
  logic        [HALF_W-1:0] half_x, half_y, half_z;

  modport source (output valid, center_x, center_y, center_z, move_x, move_y, move_z,
                  box_x, box_y, box_z, half_x, half_y, half_z, input ready);
  modport sink (input valid, center_x, center_y, center_z, move_x, move_y, move_z,
                box_x, box_y, box_z, half_x, half_y, half_z, output ready);
endinterface

interface ssbh_out_if;
  import ssbh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [TIME_BITS:0]   hit_time;
  logic signed [1:0]    normal_x, normal_y, normal_z;

  modport source (output valid, hit, hit_time, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, hit, hit_time, normal_x, normal_y, normal_z, output ready);
endinterface

[rtl/swept_sphere_box_hit.sv]
// swept sphere against axis-aligned box: front stage, pipelined dividers, slab merge, output register
// one item per cycle unless stalled; six pipelined dividers (one quotient bit per stage) set depth
// a stalled result holds the whole pipeline in place; nothing is dropped or repeated
// synchronous active-high reset clears valid bits and sets radius to 0.5
// depends on ssbh_pkg, ssbh_if, ssbh_front, ssbh_div, ssbh_merge
module swept_sphere_box_hit (
  input  logic                         clk,
  input  logic                         rst,
  ssbh_in_if.sink                      query,
  ssbh_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssbh_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ssbh_pkg::*;

  // configuration: one register at byte address 0
  logic [HALF_W-1:0] radius;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? {1'b0, radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS) begin
      radius <= pwdata[HALF_W-1:0];
    end
  end

  // global pipeline advance: moves whenever the output register is free or drained
  logic en;
  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  // per-axis front stage
  logic signed [CRD_W-1:0]  c_a [3];
  logic signed [CRD_W-1:0]  m_a [3];
  logic signed [CRD_W-1:0]  b_a [3];
  logic        [HALF_W-1:0] h_a [3];
  logic signed [NUM_W-1:0]  num_lo [3];
  logic signed [NUM_W-1:0]  num_hi [3];
  logic signed [CRD_W-1:0]  den [3];
  logic [2:0]               still;
  logic [2:0]               contained;
  time_t                    t_lo [3];
  time_t                    t_hi [3];

  assign c_a[0] = query.center_x;
  assign c_a[1] = query.center_y;
  assign c_a[2] = query.center_z;
  assign m_a[0] = query.move_x;
  assign m_a[1] = query.move_y;
  assign m_a[2] = query.move_z;
  assign b_a[0] = query.box_x;
  assign b_a[1] = query.box_y;
  assign b_a[2] = query.box_z;
  assign h_a[0] = query.half_x;
  assign h_a[1] = query.half_y;
  assign h_a[2] = query.half_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    ssbh_front u_front (
      .clk       (clk),
      .en        (en),
      .center    (c_a[a]),
      .move      (m_a[a]),
      .box       (b_a[a]),
      .half      (h_a[a]),
      .radius    (radius),
      .num_lo    (num_lo[a]),
      .num_hi    (num_hi[a]),
      .den       (den[a]),
      .still     (still[a]),
      .contained (contained[a])
    );

    // entry/exit times for the lower and upper face of the grown slab
    ssbh_div u_div_lo (
      .clk  (clk),
      .en   (en),
      .num  (num_lo[a]),
      .den  (den[a]),
      .quot (t_lo[a])
    );

    ssbh_div u_div_hi (
      .clk  (clk),
      .en   (en),
      .num  (num_hi[a]),
      .den  (den[a]),
      .quot (t_hi[a])
    );
  end

  // valid bits and still/containment flags ride alongside the dividers
  logic  pipe_valid [0:DIV_LAT];
  side_t side_pipe  [1:DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DIV_LAT; j++) pipe_valid[j] <= 1'b0;
    end else if (en) begin
      pipe_valid[0] <= query.valid;
      for (int j = 1; j <= DIV_LAT; j++) pipe_valid[j] <= pipe_valid[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[1] <= '{still: still, contained: contained};
      for (int j = 2; j <= DIV_LAT; j++) side_pipe[j] <= side_pipe[j-1];
    end
  end

  // slab merge and output register
  res_t res;

  ssbh_merge u_merge (
    .t_lo (t_lo),
    .t_hi (t_hi),
    .side (side_pipe[DIV_LAT]),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= pipe_valid[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.hit      <= res.hit;
      result.hit_time <= res.hit_time;
      result.normal_x <= res.normal_x;
      result.normal_y <= res.normal_y;
      result.normal_z <= res.normal_z;
    end
  end

endmodule

[rtl/ssbh_front.sv]
// per-axis front stage: grown slab bounds relative to the centre, still test, containment test
// depends on ssbh_pkg
module ssbh_front (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ssbh_pkg::CRD_W-1:0]  center,
  input  logic signed [ssbh_pkg::CRD_W-1:0]  move,
  input  logic signed [ssbh_pkg::CRD_W-1:0]  box,
  input  logic        [ssbh_pkg::HALF_W-1:0] half,
  input  logic        [ssbh_pkg::HALF_W-1:0] radius,
  output logic signed [ssbh_pkg::NUM_W-1:0]  num_lo,
  output logic signed [ssbh_pkg::NUM_W-1:0]  num_hi,
  output logic signed [ssbh_pkg::CRD_W-1:0]  den,
  output logic                              still,
  output logic                              contained
);
  import ssbh_pkg::*;

  logic signed [NUM_W-1:0] rel;
  logic signed [NUM_W-1:0] grow;
  logic        [CRD_W-1:0] mag;
  logic                    still_c;

  // box centre relative to sphere centre, grown half extent
  assign rel  = NUM_W'(box) - NUM_W'(center);
  assign grow = $signed({{(NUM_W-HALF_W){1'b0}}, half}) +
                $signed({{(NUM_W-HALF_W){1'b0}}, radius});
  assign mag     = move[CRD_W-1] ? CRD_W'(-move) : CRD_W'(move);
  assign still_c = mag < STILL_LIM;

  always_ff @(posedge clk) begin
    if (en) begin
      num_lo <= rel - grow;
      num_hi <= rel + grow;
      den    <= move;
      still  <= still_c;
    end
  end

  // centre within the slab: lo - c <= 0 and hi - c >= 0
  assign contained = (num_lo <= 0) && !num_hi[NUM_W-1];

endmodule

[rtl/ssbh_div.sv]
// pipelined restoring divider: (num << 16) / den, truncated and saturated
// one quotient bit per stage; depends on ssbh_pkg
module ssbh_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ssbh_pkg::NUM_W-1:0] num,
  input  logic signed [ssbh_pkg::CRD_W-1:0] den,
  output ssbh_pkg::time_t                  quot
);
  import ssbh_pkg::*;

  logic [MAG_W-1:0]  un0;
  logic [CRD_W-1:0]  ud0;
  logic              neg0;

  logic [REM_W-1:0]  rem [0:QUOT_W];
  logic [CRD_W-1:0]  ud  [0:QUOT_W];
  logic [QUOT_W-1:0] q   [0:QUOT_W];
  logic              ovf [0:QUOT_W];
  logic              neg [0:QUOT_W];

  logic [QUOT_W-1:0] qs;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      un0  <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      ud0  <= den[CRD_W-1] ? CRD_W'(-den) : CRD_W'(den);
      neg0 <= num[NUM_W-1] ^ den[CRD_W-1];
    end
  end

  // quotient of 2^18 or more saturates straight away
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= {1'b0, un0} >= {{(MAG_W-CRD_W-1){1'b0}}, ud0, 2'b00};
      rem[0] <= {un0, {TIME_BITS{1'b0}}};
      ud[0]  <= ud0;
      q[0]   <= '0;
      neg[0] <= neg0;
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_step
    localparam int K = QUOT_W - 1 - i;
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;
    assign sh   = {{(REM_W-CRD_W){1'b0}}, ud[i]} << K;
    assign diff = {1'b0, rem[i]} - {1'b0, sh};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= diff[REM_W] ? rem[i] : diff[REM_W-1:0];
        q[i+1]   <= q[i] | (QUOT_W'(!diff[REM_W]) << K);
        ud[i+1]  <= ud[i];
        ovf[i+1] <= ovf[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  assign qs = (ovf[QUOT_W] || q[QUOT_W] > QUOT_SAT) ? QUOT_SAT : q[QUOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg[QUOT_W] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    end
  end

endmodule

[rtl/ssbh_merge.sv]
// slab merge over x, y, z: latest entry, earliest exit, hit normal
// depends on ssbh_pkg
module ssbh_merge (
  input  ssbh_pkg::time_t t_lo [3],
  input  ssbh_pkg::time_t t_hi [3],
  input  ssbh_pkg::side_t side,
  output ssbh_pkg::res_t  res
);
  import ssbh_pkg::*;

  always_comb begin
    time_t      tmin;
    time_t      tmax;
    time_t      t_in;
    time_t      t_out;
    logic [1:0] nrm [3];
    logic [1:0] sgn;
    logic       miss;
    logic       hit;
    tmin = '0;
    tmax = TIME_ONE;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) nrm[a] = NORM_ZERO;
    for (int a = 0; a < 3; a++) begin
      if (side.still[a]) begin
        t_in  = '0;
        t_out = '0;
        sgn   = NORM_ZERO;
      end else if (t_lo[a] > t_hi[a]) begin
        t_in  = t_hi[a];
        t_out = t_lo[a];
        sgn   = NORM_POS;
      end else begin
        t_in  = t_lo[a];
        t_out = t_hi[a];
        sgn   = NORM_NEG;
      end
      if (!miss) begin
        if (side.still[a]) begin
          if (!side.contained[a]) miss = 1'b1;
        end else begin
          if (t_in > tmin) begin
            tmin = t_in;
            for (int b = 0; b < 3; b++) nrm[b] = NORM_ZERO;
            nrm[a] = sgn;
          end
          if (t_out < tmax) tmax = t_out;
          if (tmin > tmax) miss = 1'b1;
        end
      end
    end
    hit = !miss && !tmin[TIME_W-1] && (tmin <= TIME_ONE);
    res.hit      = hit;
    res.hit_time = hit ? tmin[TIME_BITS:0] : '0;
    res.normal_x = hit ? nrm[0] : NORM_ZERO;
    res.normal_y = hit ? nrm[1] : NORM_ZERO;
    res.normal_z = hit ? nrm[2] : NORM_ZERO;
  end

endmodule

[rtl/ssbh_check.sv]
// port-level checks on the result channel of swept_sphere_box_hit
// depends on ssbh_pkg; bound to the top level below
module ssbh_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          valid,
  input logic                          ready,
  input logic                          hit,
  input logic [ssbh_pkg::TIME_BITS:0]  hit_time,
  input logic [1:0]                    normal_x,
  input logic [1:0]                    normal_y,
  input logic [1:0]                    normal_z
);
  import ssbh_pkg::*;

  // a miss carries no time and no normal
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !hit |-> hit_time == '0 && normal_x == NORM_ZERO &&
                      normal_y == NORM_ZERO && normal_z == NORM_ZERO)
    else $error("miss with non-zero fields");

  // contact time never beyond the end of the sweep
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    valid && hit |-> hit_time <= TIME_ONE[TIME_BITS:0])
    else $error("hit time above one");

  // the normal lies on one axis at most and never reads as -2
  a_normal_axis: assert property (@(posedge clk) disable iff (rst)
    valid |-> $countones({normal_x != NORM_ZERO, normal_y != NORM_ZERO,
                          normal_z != NORM_ZERO}) <= 1 &&
              normal_x != 2'b10 && normal_y != 2'b10 && normal_z != 2'b10)
    else $error("bad hit normal");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(hit) && $stable(hit_time))
    else $error("stalled result changed");

endmodule

bind swept_sphere_box_hit ssbh_check u_ssbh_check (
  .clk      (clk),
  .rst      (rst),
  .valid    (result.valid),
  .ready    (result.ready),
  .hit      (result.hit),
  .hit_time (result.hit_time),
  .normal_x (result.normal_x),
  .normal_y (result.normal_y),
  .normal_z (result.normal_z)
);

[tb/sv/swept_sphere_box_hit_tb.sv]
// testbench for the swept sphere against box hit test: directed table then random sweeps
// results are checked field by field against a local slab-test predictor or a hand-typed expectation
// depends on ssbh_pkg, ssbh_if and the swept_sphere_box_hit rtl
`timescale 1ns / 100ps

module swept_sphere_box_hit_tb;
  import ssbh_pkg::*;

  localparam int LATENCY     = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 900;

  typedef struct {
    logic signed [31:0] c [3];
    logic signed [31:0] m [3];
    logic signed [31:0] b [3];
    logic [30:0]        h [3];
  } sweep_t;

  typedef struct {
    logic              hit;
    logic [16:0]       hit_time;
    logic signed [1:0] n [3];
  } contact_t;

  // one row of the directed table; has_exp marks a hand-typed expectation
  typedef struct {
    sweep_t   s;
    bit       has_exp;
    contact_t e;
  } row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ssbh_in_if  query ();
  ssbh_out_if result ();

  swept_sphere_box_hit uut (
    .clk(clk), .rst(rst), .query(query.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor's copy of the radius register
  logic [30:0] radius_model;

  contact_t contact_q [$];
  int       errors;
  int       cycles;
  bit       hold_off;     // long receiver stall, driven by its own process
  row_t     table_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // (num << 16) / den truncated toward zero, saturated to +-2.0
  function automatic longint entry_quot(longint num, longint den);
    bit neg;
    longint un, ud, q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un <<< 16) / ud;
    if (q > 131072) q = 131072;
    return neg ? -q : q;
  endfunction

  // slab test over the grown box
  function automatic contact_t slab_contact(sweep_t s);
    contact_t r;
    longint tmin, tmax, c, d, lo, hi, hh, ad, t1, t2, tmp;
    int sgn;
    bit hit;
    tmin = 0;
    tmax = 65536;
    hit = 1'b1;
    r.n[0] = 0; r.n[1] = 0; r.n[2] = 0;
    for (int a = 0; a < 3; a++) begin
      c = longint'(s.c[a]);
      d = longint'(s.m[a]);
      hh = longint'(s.h[a]) + longint'(radius_model);
      lo = longint'(s.b[a]) - hh;
      hi = longint'(s.b[a]) + hh;
      ad = d < 0 ? -d : d;
      if (ad * 100000 < (longint'(1) << FRAC_BITS)) begin
        // still axis: containment only
        if (c < lo || c > hi) begin
          hit = 1'b0;
          break;
        end
        continue;
      end
      t1 = entry_quot(lo - c, d);
      t2 = entry_quot(hi - c, d);
      if (t1 > t2) begin
        tmp = t1; t1 = t2; t2 = tmp;
        sgn = 1;
      end else begin
        sgn = -1;
      end
      if (t1 > tmin) begin
        tmin = t1;
        r.n[0] = 0; r.n[1] = 0; r.n[2] = 0;
        r.n[a] = 2'(sgn);
      end
      if (t2 < tmax) tmax = t2;
      if (tmin > tmax) begin
        hit = 1'b0;
        break;
      end
    end
    if (hit && (tmin < 0 || tmin > 65536)) hit = 1'b0;
    r.hit = hit;
    r.hit_time = hit ? 17'(tmin) : 17'd0;
    if (!hit) begin
      r.n[0] = 0; r.n[1] = 0; r.n[2] = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // ---------------- result side: stall pattern and checking ----------------
  int stall_mode;

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off) begin
      result.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        default: result.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    contact_t e;
    if (!rst && result.valid && result.ready) begin
      if (contact_q.size() == 0) begin
        errors++;
        $display("unexpected result item at cycle %0d", cycles);
      end else begin
        e = contact_q.pop_front();
        if (result.hit !== e.hit) report_mismatch("hit", result.hit, e.hit);
        if (result.hit_time !== e.hit_time)
          report_mismatch("hit_time", result.hit_time, e.hit_time);
        if (result.normal_x !== e.n[0]) report_mismatch("normal_x", result.normal_x, e.n[0]);
        if (result.normal_y !== e.n[1]) report_mismatch("normal_y", result.normal_y, e.n[1]);
        if (result.normal_z !== e.n[2]) report_mismatch("normal_z", result.normal_z, e.n[2]);
      end
    end
  end

  // long hold-off: receiver stops while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (cycles > 600);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------- configuration port ----------------
  task automatic write_radius(logic [30:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_RADIUS) << 2;
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    radius_model = value;
  endtask

  // ---------------- query side ----------------
  int burst_left;

  task automatic send_sweep(sweep_t s, bit has_exp, contact_t e);
    // random gaps between bursts
    if (burst_left == 0) begin
      query.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    query.valid <= 1'b1;
    query.center_x <= s.c[0]; query.center_y <= s.c[1]; query.center_z <= s.c[2];
    query.move_x <= s.m[0]; query.move_y <= s.m[1]; query.move_z <= s.m[2];
    query.box_x <= s.b[0]; query.box_y <= s.b[1]; query.box_z <= s.b[2];
    query.half_x <= s.h[0]; query.half_y <= s.h[1]; query.half_z <= s.h[2];
    do @(posedge clk); while (!query.ready);
    contact_q.push_back(has_exp ? e : slab_contact(s));
  endtask

  task automatic drain_results();
    query.valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int scale);
    case (scale)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  // well-formed sweep aimed at a nearby box, with random content
  function automatic sweep_t aimed_sweep();
    sweep_t s;
    int sc;
    sc = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
    for (int a = 0; a < 3; a++) begin
      s.b[a] = rand_coord(sc);
      s.h[a] = sc == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h0004_0000));
      s.c[a] = s.b[a] + rand_coord(sc == 0 ? 0 : 1);
      case ($urandom_range(0, 5))
        0: s.m[a] = 0;
        1: s.m[a] = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
        2: s.m[a] = rand_coord(0);
        default: s.m[a] = (s.b[a] - s.c[a]) + ($signed($urandom_range(0, 32'h0002_0000))
                          - 32'sh0001_0000);
      endcase
    end
    return s;
  endfunction

  function automatic sweep_t make_sweep(longint cx, longint mx, longint bx, longint hx);
    sweep_t s;
    for (int a = 0; a < 3; a++) begin
      s.c[a] = 0; s.m[a] = 0; s.b[a] = 0; s.h[a] = 31'h0001_0000;
    end
    s.c[0] = 32'(cx); s.m[0] = 32'(mx); s.b[0] = 32'(bx); s.h[0] = 31'(hx);
    return s;
  endfunction

  function automatic contact_t miss_contact();
    contact_t e;
    e.hit = 0; e.hit_time = 0;
    e.n[0] = 0; e.n[1] = 0; e.n[2] = 0;
    return e;
  endfunction

  task automatic add_row(sweep_t s, bit has_exp, contact_t e);
    row_t r;
    r.s = s; r.has_exp = has_exp; r.e = e;
    table_rows.push_back(r);
  endtask

  initial begin
    sweep_t s;
    contact_t e, none;
    logic [30:0] radii [4];
    burst_left = 0;
    stall_mode = 0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    query.valid = 0;
    query.center_x = 0; query.center_y = 0; query.center_z = 0;
    query.move_x = 0; query.move_y = 0; query.move_z = 0;
    query.box_x = 0; query.box_y = 0; query.box_z = 0;
    query.half_x = 0; query.half_y = 0; query.half_z = 0;
    radius_model = RADIUS_RESET;
    none = miss_contact();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset radius of one half
    // no motion at all, centre inside: hit at time 0, zero normal
    e = none; e.hit = 1;
    add_row(make_sweep(0, 0, 0, 31'h0001_0000), 1, e);
    // no motion, centre outside: miss
    add_row(make_sweep(32'sh0010_0000, 0, 0, 31'h0001_0000), 1, none);
    // head-on entry along +x from -4: grown lower face at -1.5, contact at 0.3125
    add_row(make_sweep(-32'sh0004_0000, 32'sh0008_0000, 0, 31'h0001_0000), 0, none);
    // entry along -x gives a positive normal
    add_row(make_sweep(32'sh0004_0000, -32'sh0008_0000, 0, 31'h0001_0000), 0, none);
    // moving away: miss
    add_row(make_sweep(32'sh0004_0000, 32'sh0008_0000, 0, 31'h0001_0000), 0, none);
    // too short a sweep: miss
    add_row(make_sweep(-32'sh0010_0000, 32'sh0001_0000, 0, 31'h0001_0000), 0, none);
    // one lsb of motion already counts as moving, inside and outside
    add_row(make_sweep(0, 32'sd1, 0, 31'h0001_0000), 0, none);
    add_row(make_sweep(32'sh0010_0000, -32'sd1, 0, 31'h0001_0000), 1, none);
    // smallest motion that counts as moving
    add_row(make_sweep(-32'sh0002_0000, 32'sd1, 0, 31'h0001_0000), 0, none);
    // touching the grown face exactly
    add_row(make_sweep(32'sh0001_8000, 0, 0, 31'h0001_0000), 1, e);
    // extremes of every field
    add_row(make_sweep(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff),
            0, none);
    add_row(make_sweep(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff),
            0, none);
    add_row(make_sweep(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0), 0, none);
    add_row(make_sweep(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0), 0, none);
    s = make_sweep(-32'sh0003_0000, 32'sh0004_0000, 0, 31'h0001_0000);
    s.c[1] = -32'sh0002_0000; s.m[1] = 32'sh0004_0000;
    s.c[2] = -32'sh0001_0000; s.m[2] = 32'sh0004_0000;
    add_row(s, 0, none);
    foreach (s.c[a]) begin
      s.c[a] = -1; s.m[a] = -1; s.b[a] = -1; s.h[a] = 31'h7fff_ffff;
    end
    add_row(s, 0, none);

    foreach (table_rows[i]) send_sweep(table_rows[i].s, table_rows[i].has_exp, table_rows[i].e);
    drain_results();

    // random sweeps over several radius settings, extremes among them
    radii[0] = 0;
    radii[1] = 31'h7fff_ffff;
    radii[2] = 31'($urandom_range(0, 32'h0002_0000));
    radii[3] = 31'($urandom());
    for (int p = 0; p < 4; p++) begin
      write_radius(radii[p]);
      stall_mode = p % 3;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: fully random fields
          foreach (s.c[a]) begin
            s.c[a] = $urandom(); s.m[a] = $urandom(); s.b[a] = $urandom();
            s.h[a] = 31'($urandom());
          end
        end else begin
          s = aimed_sweep();
        end
        send_sweep(s, 0, none);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ssbh_pkg.sv
rtl/ssbh_if.sv
rtl/ssbh_front.sv
rtl/ssbh_div.sv
rtl/ssbh_merge.sv
rtl/swept_sphere_box_hit.sv
rtl/ssbh_check.sv
tb/sv/swept_sphere_box_hit_tb.sv
